### rtl/sha256_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared concurrent assertion forms for the hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Payload types, round constants and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } t_out_item;

    typedef logic [31:0] t_word;

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### rtl/sha_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short FIFO that decouples the byte front end from the compression engine.
// ----------------------------------------------------------------------------
module sha_queue
    import sha_pkg::*;
#(
    parameter int unsigned P_DEPTH = QueueDepth
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_in_item o_data
);

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;

    t_in_item       r_mem [P_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW + 1)'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW + 1)'(i_push && !o_full) - (AW + 1)'(i_pop && !o_empty);
        end
    end

endmodule

### rtl/sha_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine
// Absorbs bytes, pads at message end, runs 64 rounds per block, emits digest.
// ----------------------------------------------------------------------------
module sha_engine
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_in_item  i_item,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    t_state        r_state;
    t_word         r_w [16];
    t_word         r_h [8];
    t_word         r_v [8];
    logic [63:0]   r_len;
    logic [5:0]    r_round;
    logic [3:0]    r_pad_idx;
    logic          r_final;
    logic          r_len_pend;
    logic          r_last_blk;
    logic [1:0]    r_part;
    logic          r_valid;
    t_out_item     r_out;

    logic [5:0]    w_pos;
    t_word         w_wt;
    t_word         w_new;
    t_word         w_t1;
    t_word         w_t2;
    logic          w_take;

    assign w_pos   = r_len[8:3];
    assign o_valid = r_valid;
    assign o_item  = r_out;
    assign w_take  = (r_state == S_LOAD) && !i_empty;
    assign o_pop   = w_take;

    assign w_new = small_s1(r_w[14]) + r_w[9] + small_s0(r_w[1]) + r_w[0];
    assign w_wt  = r_w[0];
    assign w_t1  = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                 + RoundK[r_round] + w_wt;
    assign w_t2  = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_len      <= '0;
            r_round    <= '0;
            r_pad_idx  <= '0;
            r_final    <= 1'b0;
            r_len_pend <= 1'b0;
            r_last_blk <= 1'b0;
            r_part     <= '0;
            r_valid    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= InitHash[i];
            end
        end else begin
            if (r_valid && i_ready && r_state != S_EMIT) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_take) begin
                        if (i_item.byte_present) begin
                            r_w[w_pos[5:2]] <= {r_w[w_pos[5:2]][23:0], i_item.data_byte};
                            r_len <= r_len + 64'd8;
                        end
                        if (i_item.byte_present && w_pos == 6'd63) begin
                            r_final    <= i_item.message_end;
                            r_len_pend <= i_item.message_end;
                            r_last_blk <= 1'b0;
                            r_round    <= '0;
                            r_v        <= r_h;
                            r_state    <= S_ROUND;
                        end else if (i_item.message_end) begin
                            r_final <= 1'b1;
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // append 0x80, zero-fill the rest of the block and place the length in words 14-15 if it fits
                    r_len_pend <= (w_pos >= 6'd56);
                    r_last_blk <= (w_pos < 6'd56);
                    r_pad_idx  <= w_pos[5:2] + 4'd1;
                    case (w_pos[1:0])
                        2'd0: r_w[w_pos[5:2]] <= {PadByte, 24'h0};
                        2'd1: r_w[w_pos[5:2]] <= {r_w[w_pos[5:2]][7:0], PadByte, 16'h0};
                        2'd2: r_w[w_pos[5:2]] <= {r_w[w_pos[5:2]][15:0], PadByte, 8'h0};
                        default: r_w[w_pos[5:2]] <= {r_w[w_pos[5:2]][23:0], PadByte};
                    endcase
                    for (int i = 0; i < 16; i++) begin
                        if (4'(i) > w_pos[5:2]) begin
                            if (w_pos < 6'd56 && i == 14) begin
                                r_w[i] <= r_len[63:32];
                            end else if (w_pos < 6'd56 && i == 15) begin
                                r_w[i] <= r_len[31:0];
                            end else begin
                                r_w[i] <= '0;
                            end
                        end
                    end
                    r_round <= '0;
                    r_v     <= r_h;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_part <= '0;
                    if (!r_final) begin
                        r_state <= S_LOAD;
                    end else if (r_last_blk) begin
                        r_state <= S_EMIT;
                    end else begin
                        // length-only block: zeros (0x80 first after a full last block), then the 64-bit length
                        for (int i = 1; i < 14; i++) begin
                            r_w[i] <= '0;
                        end
                        if (r_len_pend && w_pos == 6'd0 && r_pad_idx == 4'd0) begin
                            r_w[0] <= {PadByte, 24'h0};
                        end else begin
                            r_w[0] <= '0;
                        end
                        r_w[14]    <= r_len[63:32];
                        r_w[15]    <= r_len[31:0];
                        r_last_blk <= 1'b1;
                        r_pad_idx  <= 4'd1;
                        r_round    <= '0;
                        r_v[0] <= r_h[0] + r_v[0];
                        r_v[1] <= r_h[1] + r_v[1];
                        r_v[2] <= r_h[2] + r_v[2];
                        r_v[3] <= r_h[3] + r_v[3];
                        r_v[4] <= r_h[4] + r_v[4];
                        r_v[5] <= r_h[5] + r_v[5];
                        r_v[6] <= r_h[6] + r_v[6];
                        r_v[7] <= r_h[7] + r_v[7];
                        r_state <= S_ROUND;
                    end
                end
                S_EMIT: begin
                    if (!r_valid || i_ready) begin
                        r_valid <= 1'b1;
                        r_out.digest_part <= {r_h[{r_part, 1'b0}], r_h[{r_part, 1'b1}]};
                        r_out.part_index  <= r_part;
                        r_out.last_part   <= (r_part == 2'd3);
                        r_part <= r_part + 2'd1;
                        if (r_part == 2'd3) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= InitHash[i];
                            end
                            r_len      <= '0;
                            r_final    <= 1'b0;
                            r_last_blk <= 1'b0;
                            r_len_pend <= 1'b0;
                            r_pad_idx  <= '0;
                            r_state    <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

### rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// Operation: the engine absorbs queued bytes while loading; each full block then holds
//   the engine for 64 rounds through one shared round unit and an add step.
// It takes no new bytes while a block compresses; message end adds padding, one or
//   two compressions and four output parts, each held until taken downstream.
// Reset: synchronous active-low; chaining state to initial hash, length zero.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher top level
// Byte queue in front of the compression engine, digest out in four parts.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import sha_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QueueDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

`include "sha256_stream_hasher_assert.svh"

    logic     w_full;
    logic     w_empty;
    logic     w_pop;
    t_in_item w_head;

    assign o_ready = !w_full;

    sha_queue #(
        .P_DEPTH(P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (i_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    sha_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    `SHA_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")
    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid && o_item.last_part,
        o_item.part_index == 2'd3, "last part index mismatch")
    `SHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_item), "output changed while stalled")

endmodule

### tb/sv/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages of assorted lengths byte by byte and checks every digest
// part against a behavioral SHA-256 predictor, with random idling on both
// sides of the valid/ready handshakes.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
    import sha_pkg::*;

    localparam int unsigned CycleLimit = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    t_word       hash_state [8];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;
    t_out_item   digest_queue [$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned idle_pct;
    int unsigned sent_count;

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_word ror32(input t_word x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash_state();
        for (int i = 0; i < 8; i++) begin
            hash_state[i] = InitHash[i];
        end
        for (int i = 0; i < 64; i++) begin
            msg_block[i] = 8'h00;
        end
        msg_bits = 64'd0;
    endtask

    task automatic compress_block(input logic [7:0] blk [64]);
        t_word w [16];
        t_word v [8];
        t_word wr;
        t_word t1;
        t_word t2;
        t_word s0;
        t_word s1;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = hash_state[i];
        end
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                s1 = ror32(w[(r-2)&15], 17) ^ ror32(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                s0 = ror32(w[(r-15)&15], 7) ^ ror32(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                wr = s1 + w[(r-7)&15] + s0 + w[r&15];
                w[r&15] = wr;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + wr;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            hash_state[i] = hash_state[i] + v[i];
        end
    endtask

    task automatic predict_digest(input t_in_item item);
        int unsigned pos;
        logic [7:0]  fin [64];
        t_out_item   part;
        if (item.byte_present) begin
            pos = msg_bits[8:3];
            msg_block[pos] = item.data_byte;
            msg_bits = msg_bits + 64'd8;
            if (pos == 63) begin
                compress_block(msg_block);
            end
        end
        if (item.message_end) begin
            pos = msg_bits[8:3];
            for (int i = 0; i < 64; i++) begin
                fin[i] = (i < pos) ? msg_block[i] : 8'h00;
            end
            fin[pos] = PadByte;
            if (pos + 1 > 56) begin
                compress_block(fin);
                for (int i = 0; i < 64; i++) begin
                    fin[i] = 8'h00;
                end
            end
            for (int i = 0; i < 8; i++) begin
                fin[56+i] = msg_bits[8*(7-i) +: 8];
            end
            compress_block(fin);
            for (int k = 0; k < 4; k++) begin
                part.digest_part = {hash_state[2*k], hash_state[2*k+1]};
                part.part_index  = 2'(k);
                part.last_part   = (k == 3);
                digest_queue = {digest_queue, part};
            end
            clear_hash_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_item(input logic [7:0] data, input logic present, input logic last);
        t_in_item item;
        item.data_byte    = data;
        item.byte_present = present;
        item.message_end  = last;
        while ($urandom_range(99, 0) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (!o_ready);
        predict_digest(item);
        sent_count++;
    endtask

    task automatic send_message(input int unsigned len, input bit close_empty);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(9, 0) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, !close_empty && (i == len - 1));
        end
        if (close_empty || len == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_pad_boundaries();
        idle_pct = 0;
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        idle_pct = 36;
        send_message(63, 1'b0);
        send_message(64, 1'b1);
    endtask

    task automatic test_pause_for_digest();
        send_message(5, 1'b0);
        wait_drain();
        send_message(3, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned start;
        int unsigned len;
        start = sent_count;
        idle_pct = 36;
        while (sent_count - start < 20) begin
            len = $urandom_range(12, 0);
            send_message(len, $urandom_range(3, 0) == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected digest part", o_item.digest_part, 64'd0);
                end else begin
                    if (o_item.digest_part !== digest_queue[0].digest_part) begin
                        report_mismatch("digest_part", o_item.digest_part,
                                        digest_queue[0].digest_part);
                    end
                    if (o_item.part_index !== digest_queue[0].part_index) begin
                        report_mismatch("part_index", 64'(o_item.part_index),
                                        64'(digest_queue[0].part_index));
                    end
                    if (o_item.last_part !== digest_queue[0].last_part) begin
                        report_mismatch("last_part", 64'(o_item.last_part),
                                        64'(digest_queue[0].last_part));
                    end
                    void'(digest_queue.pop_front());
                end
            end
            i_ready <= ($urandom_range(99, 0) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        sent_count  = 0;
        idle_pct    = 36;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        clear_hash_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_pad_boundaries();
        test_pause_for_digest();
        test_random_messages();
        wait_drain();
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && digest_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
